[rtl/sfe_pkg.sv]
package sfe_pkg;

    localparam int STORE_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int DELAY_W  = 17;
    localparam int CFG_W    = 17;
    localparam int ACC_W    = 36;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(4320);

    typedef enum logic [1:0] {
        CFG_DELAY_SAMPLES = 2'd0,
        CFG_WET_MIX       = 2'd1,
        CFG_FEEDBACK_GAIN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } t_out;

    // Round a Q.16 sum to nearest (ties up) and clip to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-17:0] q;
        t = a + ACC_W'(32768);
        q = t[ACC_W-1:16];
        if (q > $signed((ACC_W-16)'(32767))) begin
            round_sat = 16'sh7fff;
        end else if (q < -$signed((ACC_W-16)'(32768))) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = q[SAMPLE_W-1:0];
        end
    endfunction

endpackage

[rtl/sfe_mix.sv]
module sfe_mix (
    input  sfe_pkg::t_in                     i_item,
    input  logic signed [15:0]               i_delayed,
    input  logic [15:0]                      i_wet_mix,
    input  logic [15:0]                      i_feedback_gain,
    output logic signed [15:0]               o_store,
    output sfe_pkg::t_out                    o_result
);
    import sfe_pkg::*;

    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W-1:0] mono;
    logic [GAIN_W:0]            dry;
    logic signed [ACC_W-1:0]    acc_store;
    logic signed [ACC_W-1:0]    wet_term;
    logic signed [ACC_W-1:0]    acc_left;
    logic signed [ACC_W-1:0]    acc_right;

    assign sum  = $signed({i_item.in_left[SAMPLE_W-1], i_item.in_left})
                + $signed({i_item.in_right[SAMPLE_W-1], i_item.in_right});
    assign mono = sum[SAMPLE_W:1];
    assign dry  = (GAIN_W+1)'(65536) - {1'b0, i_wet_mix};

    assign acc_store = ($signed(ACC_W'(mono)) <<< 16)
                     + $signed(i_delayed) * $signed({1'b0, i_feedback_gain});
    assign wet_term  = $signed(i_delayed) * $signed({1'b0, i_wet_mix});
    assign acc_left  = $signed(i_item.in_left) * $signed({1'b0, dry}) + wet_term;
    assign acc_right = $signed(i_item.in_right) * $signed({1'b0, dry}) + wet_term;

    assign o_store = round_sat(acc_store);

    always_comb begin
        if (i_wet_mix == '0) begin
            // bypass: pass the dry pair unchanged
            o_result.out_left  = i_item.in_left;
            o_result.out_right = i_item.in_right;
        end else begin
            o_result.out_left  = round_sat(acc_left);
            o_result.out_right = round_sat(acc_right);
        end
    end

endmodule

[rtl/stereo_feedback_echo.sv]
// Channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------------
// input    | i_in_valid   | o_in_ready   | i_in  (in_left, in_right)
// output   | o_out_valid  | i_out_ready  | o_out (out_left, out_right)
// config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; a result passes the
// read stage, then the output register. The delay line has one write and
// one registered read port. The item just ahead is forwarded when it writes
// the entry being read. A fill count marks unwritten entries, which read as
// zero. While the output is stalled one item waits in the read stage and
// input ready drops only when both it and the output register are full.
module stereo_feedback_echo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  sfe_pkg::t_in             i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output sfe_pkg::t_out            o_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [sfe_pkg::CFG_W-1:0] i_cfg_data
);
    import sfe_pkg::*;

    logic [DELAY_W-1:0] r_delay;
    logic [GAIN_W-1:0]  r_wet;
    logic [GAIN_W-1:0]  r_fb;

    logic [ADDR_W-1:0]  r_wp;
    logic [ADDR_W-1:0]  n_wp;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   n_fill;

    logic               r_a_valid;
    logic               r_a_write;
    logic               r_a_dl_ok;
    logic               r_a_fwd;
    logic [ADDR_W-1:0]  r_a_addr;
    t_in                r_a_item;
    logic signed [SAMPLE_W-1:0] r_fwd_data;
    logic signed [SAMPLE_W-1:0] r_mem_q;

    logic               r_out_valid;
    t_out               r_out;

    logic signed [SAMPLE_W-1:0] mem [STORE_DEPTH];

    logic               in_acc;
    logic               out_load;
    logic               a_adv;
    logic               mem_we;
    logic [31:0]        d32;
    logic [CNT_W-1:0]   d_eff;
    logic [CNT_W-1:0]   wp_x;
    logic [CNT_W-1:0]   rd_x;
    logic [ADDR_W-1:0]  rd_addr;
    logic signed [SAMPLE_W-1:0] delayed;
    logic signed [SAMPLE_W-1:0] store_val;
    t_out               result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
            r_wet   <= '0;
            r_fb    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DELAY_SAMPLES: r_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_WET_MIX:       r_wet   <= i_cfg_data[GAIN_W-1:0];
                CFG_FEEDBACK_GAIN: r_fb    <= i_cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    assign out_load   = !r_out_valid || i_out_ready;
    assign a_adv      = r_a_valid && out_load;
    assign o_in_ready = !r_a_valid || a_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign mem_we     = a_adv && r_a_write;

    // clamp the delay into 1..STORE_DEPTH
    always_comb begin
        d32 = 32'(r_delay);
        if (d32 == '0) begin
            d32 = 32'd1;
        end else if (d32 > 32'(STORE_DEPTH)) begin
            d32 = 32'(STORE_DEPTH);
        end
        d_eff = d32[CNT_W-1:0];
    end

    assign wp_x    = CNT_W'(r_wp);
    assign rd_x    = (wp_x >= d_eff) ? (wp_x - d_eff)
                                     : (wp_x + CNT_W'(STORE_DEPTH) - d_eff);
    assign rd_addr = rd_x[ADDR_W-1:0];

    always_comb begin
        n_wp   = r_wp;
        n_fill = r_fill;
        if (in_acc && r_wet != '0) begin
            n_wp = (r_wp == ADDR_W'(STORE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (r_fill != CNT_W'(STORE_DEPTH)) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_item   <= i_in;
            r_a_write  <= (r_wet != '0);
            r_a_addr   <= r_wp;
            r_a_dl_ok  <= (d_eff <= r_fill);
            // forward the value written this cycle to the entry being read
            r_a_fwd    <= mem_we && (r_a_addr == rd_addr);
            r_fwd_data <= store_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_a_addr] <= store_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    assign delayed = !r_a_dl_ok ? '0 : (r_a_fwd ? r_fwd_data : r_mem_q);

    sfe_mix u_mix (
        .i_item          (r_a_item),
        .i_delayed       (delayed),
        .i_wet_mix       (r_wet),
        .i_feedback_gain (r_fb),
        .o_store         (store_val),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= ADDR_W'(STORE_DEPTH - 1))
        else $error("write pointer out of range");

    a_bypass_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_wet == '0) |=> $stable(r_wp) && $stable(r_fill))
        else $error("bypassed item moved the delay line");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_adv) |=> r_a_valid && $stable(r_a_addr))
        else $error("stalled item lost in read stage");

    a_fwd_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_fwd) |-> r_a_dl_ok)
        else $error("forwarded entry marked unwritten");

endmodule

[bench/sfe_echo_checker.sv]
module sfe_echo_checker
    import sfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in              i_in,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out             i_out,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_pending,
    output int               o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 40;

    logic signed [SAMPLE_W-1:0] echo_line [STORE_DEPTH];
    logic [ADDR_W-1:0]          wr_pos;
    logic [DELAY_W-1:0]         delay_reg;
    logic [GAIN_W-1:0]          mix_reg;
    logic [GAIN_W-1:0]          fb_reg;
    t_out                       expected_q [$];
    t_out                       want_res;
    int                         mismatches = 0;
    int                         pending_cnt = 0;

    assign o_pending = pending_cnt;
    assign o_errors  = mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    // Round to nearest with ties up, then clip to the 16-bit sample range.
    function automatic logic signed [SAMPLE_W-1:0] q16_round_clip(input longint acc);
        longint r;
        r = (acc + 64'sd32768) >>> 16;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    // Mix one stereo pair and, unless the mix is zero, advance the delay line.
    function automatic t_out echo_predict(input t_in s);
        int                 mono;
        int                 delayed;
        int                 span;
        longint             dry;
        longint             wet;
        logic [ADDR_W-1:0]  rd_pos;
        t_out               res;
        if (mix_reg == '0) begin
            res.out_left  = s.in_left;
            res.out_right = s.in_right;
        end else begin
            mono = (int'($signed(s.in_left)) + int'($signed(s.in_right))) >>> 1;
            span = (delay_reg == '0) ? 1 : int'(delay_reg);
            if (span > STORE_DEPTH) begin
                span = STORE_DEPTH;
            end
            // Store depth is a power of two, so the address wraps on its own.
            rd_pos  = wr_pos - ADDR_W'(span);
            delayed = int'(echo_line[rd_pos]);
            echo_line[wr_pos] = q16_round_clip(longint'(mono) * 65536
                                               + longint'(delayed) * longint'(fb_reg));
            wr_pos = wr_pos + 1'b1;
            dry = 65536 - longint'(mix_reg);
            wet = longint'(delayed) * longint'(mix_reg);
            res.out_left  = q16_round_clip(longint'($signed(s.in_left)) * dry + wet);
            res.out_right = q16_round_clip(longint'($signed(s.in_right)) * dry + wet);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (echo_line[k]) echo_line[k] = '0;
            wr_pos    = '0;
            delay_reg = DELAY_RESET;
            mix_reg   = '0;
            fb_reg    = '0;
            expected_q.delete();
            pending_cnt <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result (%0d, %0d) with nothing expected",
                                              $signed(i_out.out_left),
                                              $signed(i_out.out_right)));
                end else begin
                    want_res = expected_q.pop_front();
                    if (i_out.out_left !== want_res.out_left) begin
                        report_mismatch($sformatf("out_left got %0d, expected %0d",
                                                  $signed(i_out.out_left),
                                                  $signed(want_res.out_left)));
                    end
                    if (i_out.out_right !== want_res.out_right) begin
                        report_mismatch($sformatf("out_right got %0d, expected %0d",
                                                  $signed(i_out.out_right),
                                                  $signed(want_res.out_right)));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DELAY_SAMPLES: delay_reg = i_cfg_data[DELAY_W-1:0];
                    CFG_WET_MIX:       mix_reg   = i_cfg_data[GAIN_W-1:0];
                    CFG_FEEDBACK_GAIN: fb_reg    = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(echo_predict(i_in));
            end
            pending_cnt <= expected_q.size();
        end
    end

endmodule

[bench/tb_stereo_feedback_echo.sv]
module tb_stereo_feedback_echo;
    timeunit 1ns;
    timeprecision 1ps;

    import sfe_pkg::*;

    localparam int         PHASES          = 10;
    localparam int         ITEMS_PER_PHASE = 80;
    localparam int         PRESSURE_PHASE  = 5;
    localparam int         QUIET_PHASE     = 3;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         MAX_GAP         = 15;
    localparam int         IDLE_LIMIT      = 5000;
    localparam int         TAIL_CYCLES     = 8;
    localparam logic [1:0] CFG_IDX_SPARE   = 2'd3;

    typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} t_rx_mode;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    t_in              in_item     = '0;
    logic             out_ready   = 1'b0;
    logic             cfg_valid   = 1'b0;
    logic [1:0]       cfg_index   = '0;
    logic [CFG_W-1:0] cfg_data    = '0;
    logic             in_ready;
    logic             out_valid;
    t_out             out_item;
    logic             cfg_ready;
    int               pending;
    int               errors;

    t_rx_mode         rx_mode      = RX_FREE;
    logic             hold_off_req = 1'b0;
    bit               gaps_on      = 1'b0;
    int               burst_left   = 0;
    int               idle_cycles  = 0;

    stereo_feedback_echo DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sfe_echo_checker echo_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    task automatic send_pair(input t_in s);
        if (gaps_on && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        in_valid <= 1'b1;
        in_item  <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Hold the input off until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Gain data carries a random top bit that the block must drop.
    task automatic set_echo(input logic [DELAY_W-1:0] span, input logic [GAIN_W-1:0] mix,
                            input logic [GAIN_W-1:0] fb);
        write_reg(CFG_DELAY_SAMPLES, span);
        write_reg(CFG_WET_MIX, {1'($urandom_range(0, 1)), mix});
        write_reg(CFG_FEEDBACK_GAIN, {1'($urandom_range(0, 1)), fb});
    endtask

    function automatic t_in pick_pair();
        t_in s;
        case ($urandom_range(0, 9))
            0: begin
                s.in_left  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                s.in_right = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            1: begin
                s.in_left  = 16'($urandom_range(0, 127)) - 16'd64;
                s.in_right = 16'($urandom_range(0, 127)) - 16'd64;
            end
            default: s = t_in'($urandom());
        endcase
        return s;
    endfunction

    initial begin : receiver
        int run_left;
        bit run_on;
        run_left = 0;
        run_on   = 1'b1;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                case (rx_mode)
                    RX_FREE:   out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        if (run_left == 0) begin
                            run_on   = !run_on;
                            run_left = run_on ? $urandom_range(1, 16) : $urandom_range(1, 10);
                        end
                        run_left--;
                        out_ready <= run_on;
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int               phase;
        int               n;
        logic [DELAY_W-1:0] span;
        logic [GAIN_W-1:0]  mix;
        logic [GAIN_W-1:0]  fb;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bypass with reset settings: extremes pass through untouched.
        send_pair({16'sh7fff, 16'sh8000});
        send_pair({16'sh8000, 16'sh7fff});
        send_pair('0);
        send_pair({16'shffff, 16'sh0001});
        drain_results();

        // Zero delay acts as one; full mix and feedback drive the store into clipping.
        set_echo('0, 16'hffff, 16'hffff);
        repeat (4) send_pair({16'sh7fff, 16'sh7fff});
        repeat (4) send_pair({16'sh8000, 16'sh8000});
        send_pair({16'shffff, 16'sh0000});
        send_pair({16'sh0001, 16'sh0000});
        drain_results();

        // Unused register index: the write must change nothing.
        write_reg(CFG_IDX_SPARE, '1);
        send_pair({16'sh1234, 16'shedcb});
        drain_results();

        // Longest delay reads entries not yet written since reset.
        set_echo('1, 16'h8000, 16'h0001);
        repeat (3) send_pair(pick_pair());
        drain_results();

        rx_mode <= RX_RANDOM;
        for (phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       span = '0;
                1:       span = '1;
                2:       span = DELAY_W'($urandom());
                default: span = DELAY_W'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 6))
                0:       mix = '0;
                1:       mix = '1;
                2:       mix = 16'd1;
                default: mix = GAIN_W'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0:       fb = '0;
                1:       fb = '1;
                default: fb = GAIN_W'($urandom());
            endcase
            if (phase == PRESSURE_PHASE && mix == '0) begin
                mix = 16'h4000;
            end
            set_echo(span, mix, fb);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_IDX_SPARE, CFG_W'($urandom()));
            end

            gaps_on = (phase != QUIET_PHASE && phase != PRESSURE_PHASE);
            burst_left = 0;
            if (phase == QUIET_PHASE) begin
                rx_mode <= RX_FREE;
            end else begin
                rx_mode <= (phase % 2 == 0) ? RX_BURSTY : RX_RANDOM;
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Block the output while items keep coming, so the input backs up.
                if (phase == PRESSURE_PHASE && n == 10) begin
                    hold_off_req <= 1'b1;
                end else if (phase == PRESSURE_PHASE && n == 11) begin
                    hold_off_req <= 1'b0;
                end
                send_pair(pick_pair());
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/sfe_pkg.sv
rtl/sfe_mix.sv
rtl/stereo_feedback_echo.sv
bench/sfe_echo_checker.sv
bench/tb_stereo_feedback_echo.sv
